// File: rtl/uer_pkg.sv
`timescale 1ns / 1ps
`default_nettype none

package uer_pkg;

    // default echo counter width
    localparam int COUNT_WIDTH_DEF = 32;

    // configuration port
    localparam int CFG_INDEX_W = 3;
    localparam int CFG_DATA_W  = 32;

    localparam logic [CFG_INDEX_W-1:0] REG_TRIGGER_TICKS  = 3'd0;
    localparam logic [CFG_INDEX_W-1:0] REG_GAP_TICKS      = 3'd1;
    localparam logic [CFG_INDEX_W-1:0] REG_DISTANCE_SCALE = 3'd2;
    localparam logic [CFG_INDEX_W-1:0] REG_RANGE_LOW      = 3'd3;
    localparam logic [CFG_INDEX_W-1:0] REG_RANGE_HIGH     = 3'd4;

    // register reset values
    localparam logic [15:0] TRIGGER_TICKS_RST  = 16'd500;
    localparam logic [31:0] GAP_TICKS_RST      = 32'd4500000;
    localparam logic [31:0] DISTANCE_SCALE_RST = 32'd581741;
    localparam logic [15:0] RANGE_LOW_RST      = 16'd1;
    localparam logic [15:0] RANGE_HIGH_RST     = 16'd196;

    // rounding half of a Q0.32 product and the distance ceiling
    localparam logic [64:0] ROUND_HALF = 65'h0_8000_0000;
    localparam logic [15:0] DIST_MAX   = 16'hFFFF;

    // depth of the queue between front and back
    localparam int QUEUE_DEPTH = 4;

    typedef struct packed {
        logic [15:0] trigger_ticks;
        logic [31:0] gap_ticks;
        logic [31:0] distance_scale;
        logic [15:0] range_low;
        logic [15:0] range_high;
    } t_cfg;

    // per-tick control record from the sequencer
    typedef struct packed {
        logic trigger;
        logic busy;
        logic done;
        logic rev_rise;
    } t_rec_ctl;

endpackage

`default_nettype wire

// File: rtl/ultrasonic_echo_ranger_core.sv
`timescale 1ns / 1ps
`default_nettype none

// channel  direction  handshake                 payload
// in       input      i_in_valid / o_in_ready   i_echo_level, i_in_reverse
// out      output     o_out_valid / i_out_ready trigger, busy, done, distance, range, stats
// cfg      input      i_cfg_valid / o_cfg_ready i_cfg_index, i_cfg_data
//
// one tick is taken every cycle while the queue has space; its result passes
// through the queue, a two-stage multiply and round, and the statistics register.
// the distance multiply is split into a 32 x 32 low and a narrow high product.
// reset is synchronous, active low; control state and statistics return to defaults.
// a stalled output holds the back pipeline; the queue absorbs input until full.

module ultrasonic_echo_ranger_core import uer_pkg::*; #(
    parameter int COUNT_WIDTH = COUNT_WIDTH_DEF
) (
    input  wire logic                   i_clk,
    input  wire logic                   i_rst_n,
    input  wire logic                   i_in_valid,
    output logic                        o_in_ready,
    input  wire logic                   i_echo_level,
    input  wire logic                   i_in_reverse,
    output logic                        o_out_valid,
    input  wire logic                   i_out_ready,
    output logic                        o_trigger_level,
    output logic                        o_busy_res,
    output logic                        o_reading_done,
    output logic [15:0]                 o_distance,
    output logic                        o_in_range,
    output logic [15:0]                 o_max_distance,
    output logic [15:0]                 o_min_distance,
    input  wire logic                   i_cfg_valid,
    output logic                        o_cfg_ready,
    input  wire logic [CFG_INDEX_W-1:0] i_cfg_index,
    input  wire logic [CFG_DATA_W-1:0]  i_cfg_data
);

    localparam int REC_W = $bits(t_rec_ctl) + COUNT_WIDTH;

    t_cfg                   r_cfg;
    logic                   space;
    logic                   push, pop, full, empty;
    t_rec_ctl               front_ctl, head_ctl;
    logic [COUNT_WIDTH-1:0] front_count, head_count;
    logic [REC_W-1:0]       head_rec;

    // configuration registers
    assign o_cfg_ready = 1'b1;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg.trigger_ticks  <= TRIGGER_TICKS_RST;
            r_cfg.gap_ticks      <= GAP_TICKS_RST;
            r_cfg.distance_scale <= DISTANCE_SCALE_RST;
            r_cfg.range_low      <= RANGE_LOW_RST;
            r_cfg.range_high     <= RANGE_HIGH_RST;
        end else if (i_cfg_valid) begin
            case (i_cfg_index)
                REG_TRIGGER_TICKS:  r_cfg.trigger_ticks  <= i_cfg_data[15:0];
                REG_GAP_TICKS:      r_cfg.gap_ticks      <= i_cfg_data;
                REG_DISTANCE_SCALE: r_cfg.distance_scale <= i_cfg_data;
                REG_RANGE_LOW:      r_cfg.range_low      <= i_cfg_data[15:0];
                REG_RANGE_HIGH:     r_cfg.range_high     <= i_cfg_data[15:0];
                default:            r_cfg                <= r_cfg;
            endcase
        end
    end

    assign space = !full;

    // tick sequencer
    uer_front #(
        .COUNT_WIDTH (COUNT_WIDTH)
    ) u_front (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_cfg        (r_cfg),
        .i_valid      (i_in_valid),
        .o_ready      (o_in_ready),
        .i_echo_level (i_echo_level),
        .i_in_reverse (i_in_reverse),
        .i_space      (space),
        .o_push       (push),
        .o_ctl        (front_ctl),
        .o_count      (front_count)
    );

    // record queue
    uer_fifo #(
        .WIDTH (REC_W),
        .DEPTH (QUEUE_DEPTH)
    ) u_fifo (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (push),
        .i_wdata ({front_ctl, front_count}),
        .o_full  (full),
        .i_pop   (pop),
        .o_rdata (head_rec),
        .o_empty (empty)
    );

    assign head_ctl   = t_rec_ctl'(head_rec[REC_W-1:COUNT_WIDTH]);
    assign head_count = head_rec[COUNT_WIDTH-1:0];

    // distance conversion and statistics
    uer_back #(
        .COUNT_WIDTH (COUNT_WIDTH)
    ) u_back (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .i_cfg           (r_cfg),
        .i_empty         (empty),
        .i_ctl           (head_ctl),
        .i_count         (head_count),
        .o_pop           (pop),
        .o_valid         (o_out_valid),
        .i_ready         (i_out_ready),
        .o_trigger_level (o_trigger_level),
        .o_busy_res      (o_busy_res),
        .o_reading_done  (o_reading_done),
        .o_distance      (o_distance),
        .o_in_range      (o_in_range),
        .o_max_distance  (o_max_distance),
        .o_min_distance  (o_min_distance)
    );

endmodule

`default_nettype wire

// File: rtl/uer_front.sv
`timescale 1ns / 1ps
`default_nettype none

module uer_front import uer_pkg::*; #(
    parameter int COUNT_WIDTH = COUNT_WIDTH_DEF
) (
    input  wire logic                   i_clk,
    input  wire logic                   i_rst_n,
    input  wire t_cfg                   i_cfg,
    input  wire logic                   i_valid,
    output logic                        o_ready,
    input  wire logic                   i_echo_level,
    input  wire logic                   i_in_reverse,
    input  wire logic                   i_space,
    output logic                        o_push,
    output t_rec_ctl                    o_ctl,
    output logic [COUNT_WIDTH-1:0]      o_count
);

    localparam int CNT_W = (COUNT_WIDTH > 32) ? COUNT_WIDTH : 32;
    localparam logic [CNT_W-1:0] COUNT_MAX = CNT_W'({COUNT_WIDTH{1'b1}});

    localparam logic [2:0] PH_IDLE = 3'd0;
    localparam logic [2:0] PH_TRIG = 3'd1;
    localparam logic [2:0] PH_WAIT = 3'd2;
    localparam logic [2:0] PH_MEAS = 3'd3;
    localparam logic [2:0] PH_GAP  = 3'd4;

    logic [2:0]       r_phase, n_phase;
    logic [CNT_W-1:0] r_tick, n_tick;
    logic             r_rev_before, n_rev_before;
    logic             accept;
    logic             done;

    assign o_ready = i_space;
    assign accept  = i_valid && i_space;

    // phase sequencer, one step per accepted tick
    always_comb begin
        n_phase      = r_phase;
        n_tick       = r_tick;
        n_rev_before = r_rev_before;
        done         = 1'b0;
        if (accept) begin
            n_rev_before = i_in_reverse;
            case (r_phase)
                PH_IDLE: begin
                    if (i_in_reverse) begin
                        n_phase = PH_TRIG;
                        n_tick  = CNT_W'(1);
                    end
                end
                PH_TRIG: begin
                    if (r_tick >= CNT_W'(i_cfg.trigger_ticks)) begin
                        n_phase = PH_WAIT;
                        n_tick  = '0;
                    end else begin
                        n_tick = r_tick + CNT_W'(1);
                    end
                end
                PH_WAIT: begin
                    if (i_echo_level) begin
                        n_phase = PH_MEAS;
                        n_tick  = CNT_W'(1);
                    end
                end
                PH_MEAS: begin
                    if (i_echo_level) begin
                        if (r_tick < COUNT_MAX) begin
                            n_tick = r_tick + CNT_W'(1);
                        end
                    end else begin
                        done    = 1'b1;
                        n_phase = PH_GAP;
                        n_tick  = '0;
                    end
                end
                PH_GAP: begin
                    if (r_tick >= CNT_W'(i_cfg.gap_ticks)) begin
                        n_phase = PH_IDLE;
                        n_tick  = '0;
                    end else begin
                        n_tick = r_tick + CNT_W'(1);
                    end
                end
                default: begin
                    n_phase = PH_IDLE;
                    n_tick  = '0;
                end
            endcase
        end
    end

    // record pushed into the queue
    assign o_push         = accept;
    assign o_ctl.trigger  = (n_phase == PH_TRIG);
    assign o_ctl.busy     = (n_phase != PH_IDLE);
    assign o_ctl.done     = done;
    assign o_ctl.rev_rise = i_in_reverse && !r_rev_before;
    assign o_count        = r_tick[COUNT_WIDTH-1:0];

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_phase      <= PH_IDLE;
            r_tick       <= '0;
            r_rev_before <= 1'b0;
        end else begin
            r_phase      <= n_phase;
            r_tick       <= n_tick;
            r_rev_before <= n_rev_before;
        end
    end

endmodule

`default_nettype wire

// File: rtl/uer_fifo.sv
`timescale 1ns / 1ps
`default_nettype none

module uer_fifo import uer_pkg::*; #(
    parameter int WIDTH = 8,
    parameter int DEPTH = QUEUE_DEPTH
) (
    input  wire logic             i_clk,
    input  wire logic             i_rst_n,
    input  wire logic             i_push,
    input  wire logic [WIDTH-1:0] i_wdata,
    output logic                  o_full,
    input  wire logic             i_pop,
    output logic [WIDTH-1:0]      o_rdata,
    output logic                  o_empty
);

    localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CW = $clog2(DEPTH + 1);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [AW-1:0]    r_wptr, r_rptr;
    logic [CW-1:0]    r_count;
    logic             do_push, do_pop;

    assign o_full  = (r_count == CW'(DEPTH));
    assign o_empty = (r_count == '0);
    assign do_push = i_push && !o_full;
    assign do_pop  = i_pop && !o_empty;
    assign o_rdata = r_mem[r_rptr];

    // storage
    always_ff @(posedge i_clk) begin
        if (do_push) begin
            r_mem[r_wptr] <= i_wdata;
        end
    end

    // pointers and fill level
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wptr  <= '0;
            r_rptr  <= '0;
            r_count <= '0;
        end else begin
            if (do_push) begin
                r_wptr <= (r_wptr == AW'(DEPTH - 1)) ? '0 : r_wptr + AW'(1);
            end
            if (do_pop) begin
                r_rptr <= (r_rptr == AW'(DEPTH - 1)) ? '0 : r_rptr + AW'(1);
            end
            case ({do_push, do_pop})
                2'b10:   r_count <= r_count + CW'(1);
                2'b01:   r_count <= r_count - CW'(1);
                default: r_count <= r_count;
            endcase
        end
    end

endmodule

`default_nettype wire

// File: rtl/uer_back.sv
`timescale 1ns / 1ps
`default_nettype none

module uer_back import uer_pkg::*; #(
    parameter int COUNT_WIDTH = COUNT_WIDTH_DEF
) (
    input  wire logic                   i_clk,
    input  wire logic                   i_rst_n,
    input  wire t_cfg                   i_cfg,
    input  wire logic                   i_empty,
    input  wire t_rec_ctl               i_ctl,
    input  wire logic [COUNT_WIDTH-1:0] i_count,
    output logic                        o_pop,
    output logic                        o_valid,
    input  wire logic                   i_ready,
    output logic                        o_trigger_level,
    output logic                        o_busy_res,
    output logic                        o_reading_done,
    output logic [15:0]                 o_distance,
    output logic                        o_in_range,
    output logic [15:0]                 o_max_distance,
    output logic [15:0]                 o_min_distance
);

    localparam int HI_W  = (COUNT_WIDTH > 32) ? COUNT_WIDTH - 32 : 1;
    localparam int PAD_W = 32 + HI_W;
    localparam int DW    = HI_W + 33;

    logic             advance;
    logic [PAD_W-1:0] count_pad;

    // stage 1: partial products
    logic             r_s1_valid;
    t_rec_ctl         r_s1_ctl;
    logic [63:0]      r_s1_lo;
    logic [HI_W+31:0] r_s1_hi;

    // stage 2: rounded, saturated distance
    logic             r_s2_valid;
    t_rec_ctl         r_s2_ctl;
    logic [15:0]      r_s2_dist;
    logic [64:0]      lo_round;
    logic [DW-1:0]    dist_full;

    // output stage and statistics
    logic             r_out_valid;
    t_rec_ctl         r_out_ctl;
    logic [15:0]      r_last_dist, r_max, r_min;
    logic             r_last_in_range;
    logic [15:0]      base_max, base_min;
    logic             hit;

    // whole back pipeline moves when the output slot frees
    assign advance   = !r_out_valid || i_ready;
    assign o_pop     = advance && !i_empty;
    assign count_pad = PAD_W'(i_count);

    always_ff @(posedge i_clk) begin
        if (advance) begin
            r_s1_ctl <= i_ctl;
            r_s1_lo  <= 64'(count_pad[31:0]) * 64'(i_cfg.distance_scale);
            r_s1_hi  <= (HI_W + 32)'(count_pad[PAD_W-1:32]) *
                        (HI_W + 32)'(i_cfg.distance_scale);
        end
    end

    // round the low product and fold in the high one
    assign lo_round  = {1'b0, r_s1_lo} + ROUND_HALF;
    assign dist_full = DW'(r_s1_hi) + DW'(lo_round[64:32]);

    always_ff @(posedge i_clk) begin
        if (advance) begin
            r_s2_ctl  <= r_s1_ctl;
            r_s2_dist <= (dist_full > DW'(DIST_MAX)) ? DIST_MAX : dist_full[15:0];
        end
    end

    // statistics restart on a reverse rising edge before the reading applies
    assign base_max = r_s2_ctl.rev_rise ? i_cfg.range_low  : r_max;
    assign base_min = r_s2_ctl.rev_rise ? i_cfg.range_high : r_min;
    assign hit      = (r_s2_dist >= i_cfg.range_low) && (r_s2_dist <= i_cfg.range_high);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_s1_valid      <= 1'b0;
            r_s2_valid      <= 1'b0;
            r_out_valid     <= 1'b0;
            r_last_dist     <= '0;
            r_last_in_range <= 1'b0;
            r_max           <= RANGE_LOW_RST;
            r_min           <= RANGE_HIGH_RST;
        end else if (advance) begin
            r_s1_valid  <= !i_empty;
            r_s2_valid  <= r_s1_valid;
            r_out_valid <= r_s2_valid;
            if (r_s2_valid) begin
                r_max <= base_max;
                r_min <= base_min;
                if (r_s2_ctl.done) begin
                    r_last_dist     <= r_s2_dist;
                    r_last_in_range <= hit;
                    if (hit) begin
                        r_max <= (r_s2_dist > base_max) ? r_s2_dist : base_max;
                        r_min <= (r_s2_dist < base_min) ? r_s2_dist : base_min;
                    end
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (advance) begin
            r_out_ctl <= r_s2_ctl;
        end
    end

    assign o_valid         = r_out_valid;
    assign o_trigger_level = r_out_ctl.trigger;
    assign o_busy_res      = r_out_ctl.busy;
    assign o_reading_done  = r_out_ctl.done;
    assign o_distance      = r_last_dist;
    assign o_in_range      = r_last_in_range;
    assign o_max_distance  = r_max;
    assign o_min_distance  = r_min;

endmodule

`default_nettype wire
